/* rtl/core/cse_pkg.sv */
// Shared types, constants and helpers for the cubic spline evaluator.
// No dependencies.
package cse_pkg;

  localparam int unsigned TERM_SLOTS = 4;
  localparam int unsigned IDX_W      = 3;
  localparam logic [16:0] ONE_Q16    = 17'd65536;

  typedef enum logic [1:0] {
    ACT_KNOT   = 2'd0,
    ACT_XCOEF  = 2'd1,
    ACT_YCOEF  = 2'd2,
    ACT_EVAL   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SAT   = 2'd1,
    ST_ZERO  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_RDLO,
    S_RDHI,
    S_CHECK,
    S_DIV,
    S_POW_MUL,
    S_POW_ACC,
    S_TRM_RD,
    S_TRM_MX,
    S_TRM_MY,
    S_TRM_AY,
    S_FIN
  } state_e;

  function automatic logic ovf64(input logic signed [63:0] v);
    return (v > 64'sd2147483647) || (v < -64'sd2147483648);
  endfunction

  function automatic logic signed [31:0] clamp64(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // i!/(i-order)! for the small indices used here
  function automatic logic [2:0] fall_fac(input logic [IDX_W-1:0] i,
                                          input logic [1:0] ord);
    int unsigned f;
    int unsigned j;
    f = 1;
    for (j = 0; j < 3; j++) begin
      if (j < ord) f = f * (int'(i) - j);
    end
    return f[2:0];
  endfunction

  // multiply by a factor in {1,2,3,6} with shifts and one add
  function automatic logic signed [63:0] scale_fac(input logic signed [63:0] v,
                                                   input logic [2:0] f);
    logic signed [63:0] r;
    case (f)
      3'd1:    r = v;
      3'd2:    r = v <<< 1;
      3'd3:    r = v + (v <<< 1);
      3'd6:    r = (v + (v <<< 1)) <<< 1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/cse_divider.sv */
// Restoring divider, one quotient bit per cycle, unsigned magnitudes.
// Uses cse_pkg only for house consistency of types.
module cse_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [32:0] dividend_i,
  input  logic [16:0] divisor_i,
  output logic        done_o,
  output logic [32:0] quotient_o
);
  import cse_pkg::*;

  logic [16:0] rem_q, rem_d;
  logic [32:0] quo_q, quo_d;
  logic [16:0] dvs_q;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [17:0] rem_sh;

  assign rem_sh = {rem_q, quo_q[32]};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      cnt_d  = 6'd33;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_d = 17'(rem_sh - {1'b0, dvs_q});
        quo_d = {quo_q[31:0], 1'b1};
      end else begin
        rem_d = rem_sh[16:0];
        quo_d = {quo_q[31:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) dvs_q <= divisor_i;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* rtl/core/cse_mult.sv */
// Shared signed 32x32 multiplier with a registered 64-bit product.
// Depends on nothing beyond cse_pkg.
module cse_mult (
  input  logic               clk_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic signed [63:0] prod_o
);
  import cse_pkg::*;

  logic signed [63:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

/* rtl/core/cubic_spline_evaluator_unit.sv */
// Timing: a load word is written to its table without leaving S_IDLE; an evaluate word
//   runs the segment walk (1..count+1 knot probes), the division, then the power and term loops.
// Flow: one word at a time; the 33-step divider and the segment walk
//   (two knot memory reads per probe) are the main parts of an evaluate word.
// Reset: asynchronous active low; clears the sequencer, the output valid and
//   sets segment_count to 4. Tables hold garbage until written.
module cubic_spline_evaluator_unit #(
  parameter int unsigned MAX_SEGMENTS = 64,
  parameter int unsigned DEGREE       = 3
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // config write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [6:0]         cfg_data_i,
  // input words
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         action_i,
  input  logic [6:0]         segment_i,
  input  logic [1:0]         term_i,
  input  logic signed [31:0] coefficient_i,
  input  logic [16:0]        position_i,
  input  logic [1:0]         order_i,
  // result words
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] x_value_o,
  output logic signed [31:0] y_value_o,
  output logic [1:0]         status_o
);
  import cse_pkg::*;

  localparam int unsigned KN_W  = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned SEG_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned CNT_W = KN_W;
  localparam int unsigned CA_W  = SEG_W + 2;
  localparam int unsigned PW_W  = $clog2(DEGREE + 1);
  localparam int unsigned KN_D  = MAX_SEGMENTS + 1;
  localparam int unsigned CF_D  = MAX_SEGMENTS * TERM_SLOTS;

  // ---------------------------------------------------------------------------
  // Storage: knot and coefficient tables, registered reads
  // ---------------------------------------------------------------------------
  logic [16:0]        knot_mem [KN_D];
  logic signed [31:0] xc_mem   [CF_D];
  logic signed [31:0] yc_mem   [CF_D];

  logic [16:0]        knot_rd_q;
  logic signed [31:0] xc_rd_q, yc_rd_q;
  logic [KN_W-1:0]    knot_addr;
  logic [CA_W-1:0]    coef_addr;

  // ---------------------------------------------------------------------------
  // Sequencer state and datapath registers
  // ---------------------------------------------------------------------------
  state_e state_q, state_d;

  logic [6:0]          cfg_cnt_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [16:0]         t_q;
  logic [1:0]          ord_q;
  logic [SEG_W-1:0]    n_q;
  logic [CNT_W-1:0]    steps_q;
  logic [16:0]         lo_q;
  logic                neg_q;
  logic signed [31:0]  u_q;
  logic signed [31:0]  pw_q [DEGREE+1];
  logic [IDX_W-1:0]    idx_q;
  logic signed [63:0]  xs_q, ys_q;
  logic                sat_q;
  logic                zlen_q;

  logic                out_valid_q;
  logic signed [31:0]  x_q, y_q;
  logic [1:0]          st_q;

  // shared units
  logic signed [31:0]  mul_a, mul_b;
  logic signed [63:0]  prod;
  logic                div_start, div_done;
  logic [32:0]         div_q;
  logic [32:0]         dvd;
  logic [16:0]         dvs;

  // ---------------------------------------------------------------------------
  // Input decode
  // ---------------------------------------------------------------------------
  logic        in_fire;
  logic [31:0] seg_w, cfg_w, cnt_full;
  logic [16:0] pos_clip, pos_wrap;

  assign in_fire  = in_valid_i && in_ready_o;
  assign seg_w    = {25'd0, segment_i};
  assign cfg_w    = {25'd0, cfg_cnt_q};
  assign cnt_full = (cfg_w == 32'd0) ? 32'd1 :
                    (cfg_w > MAX_SEGMENTS) ? MAX_SEGMENTS : cfg_w;
  assign pos_clip = (position_i > ONE_Q16) ? ONE_Q16 : position_i;
  assign pos_wrap = (position_i > ONE_Q16) ? 17'(position_i - ONE_Q16) : position_i;

  // ---------------------------------------------------------------------------
  // Walk check: does segment n bracket t, or has the walk run out of moves
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0]   n_ext;
  logic               lo_ok, hi_ok, walk_end;
  logic signed [17:0] den, num;
  logic [CNT_W+16:0]  nprod;
  logic [CNT_W:0]     n_raw;

  assign n_ext    = CNT_W'(n_q);
  assign lo_ok    = (n_q == '0) || (lo_q <= t_q);
  assign hi_ok    = (n_ext == cnt_q - CNT_W'(1)) || (knot_rd_q >= t_q);
  assign walk_end = (steps_q == cnt_q) || (lo_ok && hi_ok);
  assign den      = $signed({1'b0, knot_rd_q}) - $signed({1'b0, lo_q});
  assign num      = $signed({1'b0, t_q}) - $signed({1'b0, lo_q});
  assign nprod    = cnt_q * t_q;
  assign n_raw    = nprod[CNT_W+16:16];

  assign dvd = {(num < 0) ? 17'(-num) : num[16:0], 16'd0};
  assign dvs = (den < 0) ? 17'(-den) : den[16:0];

  // term bookkeeping
  logic signed [63:0] prod_fl, u_wide;
  logic [2:0]         fac;

  assign prod_fl = prod >>> 16;
  assign fac     = fall_fac(idx_q, ord_q);
  assign u_wide  = neg_q ? -$signed({31'd0, div_q}) : $signed({31'd0, div_q});

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:    if (in_fire && action_i == ACT_EVAL) state_d = S_START;
      S_START:   state_d = S_RDLO;
      S_RDLO:    state_d = S_RDHI;
      S_RDHI:    state_d = S_CHECK;
      S_CHECK: begin
        if (!walk_end)      state_d = S_RDLO;
        else if (den == 0)  state_d = S_FIN;
        else                state_d = S_DIV;
      end
      S_DIV:     if (div_done) state_d = S_POW_MUL;
      S_POW_MUL: state_d = S_POW_ACC;
      S_POW_ACC: begin
        if (32'(idx_q) != DEGREE)   state_d = S_POW_MUL;
        else if (ord_q > DEGREE)    state_d = S_FIN;
        else                        state_d = S_TRM_RD;
      end
      S_TRM_RD:  state_d = S_TRM_MX;
      S_TRM_MX:  state_d = S_TRM_MY;
      S_TRM_MY:  state_d = S_TRM_AY;
      S_TRM_AY:  state_d = (32'(idx_q) == DEGREE) ? S_FIN : S_TRM_RD;
      S_FIN:     if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer outputs: memory addresses, multiplier operands, divider start
  // ---------------------------------------------------------------------------
  always_comb begin
    in_ready_o = (state_q == S_IDLE);
    knot_addr  = KN_W'(n_q);
    coef_addr  = {n_q, idx_q[1:0]};
    mul_a      = pw_q[PW_W'(idx_q - IDX_W'(1))];
    mul_b      = u_q;
    div_start  = 1'b0;
    case (state_q)
      S_RDHI:    knot_addr = KN_W'(n_q) + KN_W'(1);
      S_CHECK:   div_start = walk_end && (den != 0);
      S_TRM_MX: begin
        mul_a = pw_q[PW_W'(idx_q - IDX_W'(ord_q))];
        mul_b = xc_rd_q;
      end
      S_TRM_MY: begin
        mul_a = pw_q[PW_W'(idx_q - IDX_W'(ord_q))];
        mul_b = yc_rd_q;
      end
      default: ;
    endcase
  end

  assign cfg_ready_o = 1'b1;

  // ---------------------------------------------------------------------------
  // Memories
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_fire && action_i == ACT_KNOT && seg_w <= MAX_SEGMENTS)
      knot_mem[seg_w[KN_W-1:0]] <= pos_clip;
    if (in_fire && action_i == ACT_XCOEF && seg_w < MAX_SEGMENTS)
      xc_mem[{seg_w[SEG_W-1:0], term_i}] <= coefficient_i;
    if (in_fire && action_i == ACT_YCOEF && seg_w < MAX_SEGMENTS)
      yc_mem[{seg_w[SEG_W-1:0], term_i}] <= coefficient_i;
    knot_rd_q <= knot_mem[knot_addr];
    xc_rd_q   <= xc_mem[coef_addr];
    yc_rd_q   <= yc_mem[coef_addr];
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cfg_cnt_q   <= 7'd4;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) cfg_cnt_q <= cfg_data_i;
      if (state_q == S_FIN && (!out_valid_q || out_ready_i)) out_valid_q <= 1'b1;
      else if (out_ready_i)                                  out_valid_q <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        t_q     <= pos_wrap;
        ord_q   <= order_i;
        cnt_q   <= cnt_full[CNT_W-1:0];
        steps_q <= '0;
        sat_q   <= 1'b0;
        zlen_q  <= 1'b0;
      end
      S_START: begin
        // first guess floor(count*t), capped at the last segment
        if (n_raw >= {1'b0, cnt_q}) n_q <= SEG_W'(cnt_q - CNT_W'(1));
        else                        n_q <= SEG_W'(n_raw);
      end
      S_RDHI: lo_q <= knot_rd_q;
      S_CHECK: begin
        if (!walk_end) begin
          if (!lo_ok) n_q <= n_q - SEG_W'(1);
          else        n_q <= n_q + SEG_W'(1);
          steps_q <= steps_q + CNT_W'(1);
        end else begin
          neg_q  <= (num < 0) ^ (den < 0);
          zlen_q <= (den == 0);
        end
      end
      S_DIV: begin
        if (div_done) begin
          u_q      <= clamp64(u_wide);
          sat_q    <= sat_q | ovf64(u_wide);
          pw_q[0]  <= 32'sd65536;
          idx_q    <= IDX_W'(1);
        end
      end
      S_POW_ACC: begin
        pw_q[PW_W'(idx_q)] <= clamp64(prod_fl);
        sat_q              <= sat_q | ovf64(prod_fl);
        if (32'(idx_q) != DEGREE) idx_q <= idx_q + IDX_W'(1);
        else                      idx_q <= IDX_W'(ord_q);
        xs_q <= '0;
        ys_q <= '0;
      end
      S_TRM_MY: xs_q <= xs_q + scale_fac(prod_fl, fac);
      S_TRM_AY: begin
        ys_q  <= ys_q + scale_fac(prod_fl, fac);
        idx_q <= idx_q + IDX_W'(1);
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          if (zlen_q) begin
            x_q  <= '0;
            y_q  <= '0;
            st_q <= ST_ZERO;
          end else begin
            x_q  <= clamp64(xs_q);
            y_q  <= clamp64(ys_q);
            st_q <= (sat_q || ovf64(xs_q) || ovf64(ys_q)) ? ST_SAT : ST_OK;
          end
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Shared arithmetic units
  // ---------------------------------------------------------------------------
  cse_mult u_mult (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  cse_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  assign out_valid_o = out_valid_q;
  assign x_value_o   = x_q;
  assign y_value_o   = y_q;
  assign status_o    = st_q;

`ifndef NO_ASSERTIONS
  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK) |-> (n_ext < cnt_q))
    else $error("walk left the segment range");
  a_steps_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK) |-> (steps_q <= cnt_q))
    else $error("walk took more moves than segments");
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside division phase");
  a_zero_len_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_ZERO) |-> (x_value_o == 0 && y_value_o == 0))
    else $error("zero-length segment word with nonzero value");
`endif

endmodule
